// File: sv/qbmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbmv_pkg
// Shared words, command codes and register indexes of the quantised
// block matrix-vector unit.
// ----------------------------------------------------------------------------
package qbmv_pkg;

  // input word: a vector element load or one quantised matrix block
  typedef struct packed {
    logic        command;
    logic [11:0] element_index;
    logic [31:0] element_value;
    logic [15:0] block_scale;
    logic [63:0] quant_word0;
    logic [63:0] quant_word1;
    logic [63:0] quant_word2;
    logic [63:0] quant_word3;
  } qbmv_in_t;

  // result word: one finished matrix row
  typedef struct packed {
    logic [11:0] row_number;
    logic [31:0] row_value;
    logic        last_row;
  } qbmv_out_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_BLOCK = 1'b1;

  localparam logic [1:0] REG_QUANT_FORMAT   = 2'd0;
  localparam logic [1:0] REG_BLOCKS_PER_ROW = 2'd1;
  localparam logic [1:0] REG_ROW_TOTAL      = 2'd2;

endpackage

// File: sv/quantized_block_matvec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_block_matvec
// Dot products of fp16-scaled 4-bit or 8-bit quantised matrix rows with a
// binary32 vector held in on-chip RAM, summed in binary64.
// ----------------------------------------------------------------------------
//
//  port group   direction  flow control         word
//  in_*         in         in_valid_i/in_stall_o  qbmv_in_t  (load or block)
//  out_*        out        out_valid_o/out_stall_i qbmv_out_t (one per row)
//  APB          in/out     psel/penable, pready=1  3 registers at 0x0,0x4,0x8
//
//  A load word is written to vector RAM when accepted. A block word runs its
//  32 elements one at a time through one binary64 adder in a serial add,
//  normalise and round loop; a zero or special element skips the add. No
//  further word is taken until the block is done. After the row's last block
//  the sum is rounded to binary32. Reset clears the sum and the counters and
//  sets the registers to 4-bit format, one block per row and one row; vector
//  RAM is not cleared. A stalled result is held in the output register while
//  the next row is worked on; a further result waits until it is taken.
// ----------------------------------------------------------------------------
module quantized_block_matvec import qbmv_pkg::*; #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  qbmv_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output qbmv_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_COLUMNS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_ALIGN = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_ROUND = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [4:0]  k_q;
  logic [7:0]  blk_q;
  logic [12:0] row_q;
  logic        out_valid_q;
  qbmv_out_t   out_data_q;
  logic        fmt_q;
  logic [7:0]  bpr_q;
  logic [12:0] rowtot_q;

  // scale and quants of the current block
  logic               sc_sign_q, sc_zero_q, sc_inf_q, sc_nan_q;
  logic [10:0]        sc_man_q;
  logic signed [11:0] sc_exp_q;
  logic [255:0]       quant_q;

  logic [18:0] m1_q;
  logic        qzero_q, qneg_q, oob_q;
  logic [31:0] rdata_q;
  logic [31:0] vmem [MAX_COLUMNS];

  // working word: [56] carry, [55:3] significand, [2:0] guard, round, sticky
  logic [56:0]        w_q;
  logic signed [11:0] w_exp_q;
  logic               phase_q;
  logic [55:0]        b_q;
  logic               sub_q, r_sign_q;
  logic [52:0]        t_man_q;
  logic signed [11:0] t_exp_q;
  logic               t_sign_q;

  // running sum: value = man * 2^(exp-52)
  logic [52:0]        acc_man_q;
  logic signed [11:0] acc_exp_q;
  logic               acc_sign_q, acc_zero_q, acc_inf_q, acc_nan_q, inf_sign_q;

  logic [23:0] fq_q;
  logic        fg_q, fs_q;
  logic [8:0]  fbase_q;

  // handshakes
  logic in_fire, cfg_we, emit_fire, elem_done;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_we      = psel && penable && pwrite;
  assign pready      = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign emit_fire   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (paddr[3:2])
      REG_QUANT_FORMAT:   prdata = {31'b0, fmt_q};
      REG_BLOCKS_PER_ROW: prdata = {24'b0, bpr_q};
      REG_ROW_TOTAL:      prdata = {19'b0, rowtot_q};
      default:            prdata = 32'b0;
    endcase
  end

  // effective block and row counts
  logic [7:0]  bpr_eff;
  logic [16:0] rows_raw, rows_eff;
  logic [7:0]  blk_inc;
  logic        blk_end, row_last;
  assign bpr_eff  = (bpr_q == 8'd0) ? 8'd1 : ((bpr_q > 8'd128) ? 8'd128 : bpr_q);
  assign rows_raw = (rowtot_q == 13'd0) ? 17'd1 : {4'b0, rowtot_q};
  assign rows_eff = (32'(rows_raw) > 32'(MAX_ROWS)) ? 17'(MAX_ROWS) : rows_raw;
  assign blk_inc  = blk_q + 8'd1;
  assign blk_end  = (blk_inc >= bpr_eff);
  assign row_last = (({4'b0, row_q} + 17'd1) >= rows_eff);

  // fp16 scale decode at accept
  logic [15:0] h;
  assign h = in_data_i.block_scale;

  // element select
  logic [4:0]  byte_idx, col_off;
  logic [7:0]  qbyte, q_mag;
  logic [3:0]  nib;
  logic        q_neg;
  logic [11:0] col;
  logic        col_oob;
  logic [18:0] m1;
  assign byte_idx = fmt_q ? k_q : {1'b0, k_q[4:1]};
  assign qbyte    = quant_q[{byte_idx, 3'b000} +: 8];
  assign nib      = k_q[0] ? qbyte[7:4] : qbyte[3:0];
  assign col_off  = fmt_q ? k_q : {k_q[0], k_q[4:1]};
  assign col      = {blk_q[6:0], col_off};
  assign col_oob  = (32'(col) >= 32'(MAX_COLUMNS));
  always_comb begin
    if (fmt_q) begin
      q_neg = qbyte[7];
      q_mag = qbyte[7] ? (~qbyte + 8'd1) : qbyte;
    end else begin
      q_neg = ~nib[3];
      q_mag = nib[3] ? {5'b0, nib[2:0]} : {4'b0, 4'd8 - nib};
    end
  end
  assign m1 = sc_man_q * q_mag;

  // term: scale * q * vector element, exact
  logic [7:0]         ve;
  logic [22:0]        vf;
  logic [23:0]        vm;
  logic signed [11:0] ev, t_exp_raw;
  logic               v_zero, v_inf, v_nan, p_nan, p_inf, p_zero;
  logic               t_nan, t_inf, t_zero, t_sign;
  logic [42:0]        m2;
  assign ve        = rdata_q[30:23];
  assign vf        = rdata_q[22:0];
  assign vm        = {ve != 8'd0, vf};
  assign ev        = (ve == 8'd0) ? -12'sd149 : ($signed({4'b0, ve}) - 12'sd150);
  assign v_zero    = oob_q || (ve == 8'd0 && vf == 23'd0);
  assign v_inf     = !oob_q && ve == 8'hff && vf == 23'd0;
  assign v_nan     = !oob_q && ve == 8'hff && vf != 23'd0;
  assign p_nan     = sc_nan_q || (sc_inf_q && qzero_q);
  assign p_inf     = sc_inf_q && !qzero_q;
  assign p_zero    = sc_zero_q || qzero_q;
  assign t_nan     = p_nan || v_nan || (p_inf && v_zero) || (p_zero && v_inf);
  assign t_inf     = !t_nan && (p_inf || v_inf);
  assign t_zero    = !t_nan && !t_inf && (p_zero || v_zero);
  assign t_sign    = sc_sign_q ^ qneg_q ^ rdata_q[31];
  assign m2        = m1_q * vm;
  assign t_exp_raw = sc_exp_q + ev + 12'sd42;

  // alignment
  logic               acc_big, big_sign, sticky;
  logic [52:0]        big_man, small_man;
  logic signed [11:0] big_exp, small_exp;
  logic [12:0]        diff;
  logic [55:0]        bext, bal;
  assign acc_big   = (acc_exp_q > t_exp_q) ||
                     (acc_exp_q == t_exp_q && acc_man_q >= t_man_q);
  assign big_man   = acc_big ? acc_man_q : t_man_q;
  assign big_exp   = acc_big ? acc_exp_q : t_exp_q;
  assign big_sign  = acc_big ? acc_sign_q : t_sign_q;
  assign small_man = acc_big ? t_man_q : acc_man_q;
  assign small_exp = acc_big ? t_exp_q : acc_exp_q;
  assign diff      = {big_exp[11], big_exp} - {small_exp[11], small_exp};
  assign bext      = {small_man, 3'b000};
  assign sticky    = |(bext & ~({56{1'b1}} << diff[5:0]));
  assign bal       = (diff >= 13'd56) ? 56'd1 : ((bext >> diff[5:0]) | 56'(sticky));

  logic [56:0] sum_w;
  assign sum_w = sub_q ? (w_q - {1'b0, b_q}) : (w_q + {1'b0, b_q});

  // round to binary64
  logic        rnd_up;
  logic [53:0] rnd_sum;
  assign rnd_up  = w_q[2] && (w_q[1] || w_q[0] || w_q[3]);
  assign rnd_sum = {1'b0, w_q[55:3]} + 54'(rnd_up);

  // binary32 conversion, first half: pick kept bits, guard and sticky
  logic               f_normal;
  logic signed [11:0] f_neg, f_base12;
  logic [5:0]         fr;
  logic [53:0]        fx, fxs;
  assign f_normal = (acc_exp_q >= -12'sd126);
  assign f_neg    = -12'sd97 - acc_exp_q;
  assign f_base12 = acc_exp_q + 12'sd126;
  assign fr       = f_normal ? 6'd29 : ((acc_exp_q < -12'sd152) ? 6'd55 : f_neg[5:0]);
  assign fx       = {acc_man_q, 1'b0};
  assign fxs      = fx >> fr;

  // second half: round and pack; carries run into the exponent field
  logic        fup;
  logic [24:0] frnd;
  logic [31:0] fval, fmag, row_bits;
  assign fup  = fg_q && (fs_q || fq_q[0]);
  assign frnd = {1'b0, fq_q} + 25'(fup);
  assign fval = {fbase_q, 23'b0} + 32'(frnd);
  assign fmag = (fval >= 32'h7f800000) ? 32'h7f800000 : fval;
  always_comb begin
    if (acc_nan_q)       row_bits = 32'h7fc00000;
    else if (acc_inf_q)  row_bits = {inf_sign_q, 31'h7f800000};
    else if (acc_zero_q) row_bits = 32'h0;
    else                 row_bits = {acc_sign_q, fmag[30:0]};
  end

  always_comb begin
    state_d   = state_q;
    elem_done = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire && in_data_i.command == CMD_BLOCK) state_d = S_READ;
      end
      S_READ: state_d = S_MUL;
      S_MUL: begin
        if (t_nan || t_inf || t_zero || acc_nan_q || acc_inf_q) elem_done = 1'b1;
        else state_d = S_NORM;
      end
      S_NORM: begin
        if (w_q[56]) state_d = S_ROUND;
        else if (w_q[55]) state_d = phase_q ? S_ROUND : S_ALIGN;
      end
      S_ALIGN: begin
        if (acc_zero_q) elem_done = 1'b1;
        else state_d = S_ADD;
      end
      S_ADD: begin
        if (sum_w == 57'd0) elem_done = 1'b1;
        else state_d = S_NORM;
      end
      S_ROUND: elem_done = 1'b1;
      S_FIN:   state_d = S_EMIT;
      S_EMIT: begin
        if (emit_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (elem_done) state_d = (k_q == 5'd31) ? (blk_end ? S_FIN : S_IDLE) : S_READ;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= 5'd0;
      blk_q       <= 8'd0;
      row_q       <= 13'd0;
      out_valid_q <= 1'b0;
      fmt_q       <= 1'b0;
      bpr_q       <= 8'd1;
      rowtot_q    <= 13'd1;
      acc_zero_q  <= 1'b1;
      acc_inf_q   <= 1'b0;
      acc_nan_q   <= 1'b0;
      inf_sign_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        case (paddr[3:2])
          REG_QUANT_FORMAT:   fmt_q    <= pwdata[0];
          REG_BLOCKS_PER_ROW: bpr_q    <= pwdata[7:0];
          REG_ROW_TOTAL:      rowtot_q <= pwdata[12:0];
          default: ;
        endcase
      end
      if (in_fire && in_data_i.command == CMD_BLOCK) k_q <= 5'd0;
      if (elem_done) begin
        k_q <= k_q + 5'd1;
        if (k_q == 5'd31) blk_q <= blk_end ? 8'd0 : blk_inc;
      end
      if (state_q == S_MUL) begin
        if (t_nan) begin
          acc_nan_q <= 1'b1;
        end else if (t_inf) begin
          // opposite infinities give NaN
          if (acc_inf_q && inf_sign_q != t_sign) acc_nan_q <= 1'b1;
          else begin
            acc_inf_q  <= 1'b1;
            inf_sign_q <= t_sign;
          end
        end
      end
      if (state_q == S_ALIGN && acc_zero_q) acc_zero_q <= 1'b0;
      if (state_q == S_ADD && sum_w == 57'd0) acc_zero_q <= 1'b1;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
        acc_zero_q  <= 1'b1;
        acc_inf_q   <= 1'b0;
        acc_nan_q   <= 1'b0;
        row_q       <= row_last ? 13'd0 : row_q + 13'd1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // vector RAM: one write port for loads, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.command == CMD_LOAD &&
        32'(in_data_i.element_index) < 32'(MAX_COLUMNS)) begin
      vmem[AW'(in_data_i.element_index)] <= in_data_i.element_value;
    end
    if (state_q == S_READ) rdata_q <= vmem[AW'(col)];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire && in_data_i.command == CMD_BLOCK) begin
          sc_sign_q <= h[15];
          sc_man_q  <= {h[14:10] != 5'd0, h[9:0]};
          sc_exp_q  <= (h[14:10] == 5'd0) ? -12'sd24 : ($signed({7'b0, h[14:10]}) - 12'sd25);
          sc_zero_q <= (h[14:10] == 5'd0) && (h[9:0] == 10'd0);
          sc_inf_q  <= (h[14:10] == 5'h1f) && (h[9:0] == 10'd0);
          sc_nan_q  <= (h[14:10] == 5'h1f) && (h[9:0] != 10'd0);
          quant_q   <= {in_data_i.quant_word3, in_data_i.quant_word2,
                        in_data_i.quant_word1, in_data_i.quant_word0};
        end
      end
      S_READ: begin
        m1_q    <= m1;
        qzero_q <= (q_mag == 8'd0);
        qneg_q  <= q_neg;
        oob_q   <= col_oob;
      end
      S_MUL: begin
        w_q      <= {1'b0, m2, 13'b0};
        w_exp_q  <= t_exp_raw;
        phase_q  <= 1'b0;
        t_sign_q <= t_sign;
      end
      S_NORM: begin
        if (w_q[56]) begin
          // carry out: shift right, fold the dropped bit into sticky
          w_q     <= {1'b0, w_q[56:2], w_q[1] | w_q[0]};
          w_exp_q <= w_exp_q + 12'sd1;
        end else if (w_q[55]) begin
          if (!phase_q) begin
            t_man_q <= w_q[55:3];
            t_exp_q <= w_exp_q;
          end
        end else if (w_q[55:40] == 16'd0) begin
          w_q     <= {w_q[40:0], 16'b0};
          w_exp_q <= w_exp_q - 12'sd16;
        end else if (w_q[55:52] == 4'd0) begin
          w_q     <= {w_q[52:0], 4'b0};
          w_exp_q <= w_exp_q - 12'sd4;
        end else begin
          w_q     <= {w_q[55:0], 1'b0};
          w_exp_q <= w_exp_q - 12'sd1;
        end
      end
      S_ALIGN: begin
        if (acc_zero_q) begin
          acc_man_q  <= t_man_q;
          acc_exp_q  <= t_exp_q;
          acc_sign_q <= t_sign_q;
        end else begin
          w_q      <= {1'b0, big_man, 3'b000};
          w_exp_q  <= big_exp;
          b_q      <= bal;
          sub_q    <= acc_sign_q ^ t_sign_q;
          r_sign_q <= big_sign;
        end
      end
      S_ADD: begin
        w_q     <= sum_w;
        phase_q <= 1'b1;
        if (sum_w == 57'd0) acc_sign_q <= 1'b0;
      end
      S_ROUND: begin
        acc_sign_q <= r_sign_q;
        if (rnd_sum[53]) begin
          acc_man_q <= rnd_sum[53:1];
          acc_exp_q <= w_exp_q + 12'sd1;
        end else begin
          acc_man_q <= rnd_sum[52:0];
          acc_exp_q <= w_exp_q;
        end
      end
      S_FIN: begin
        fq_q    <= fxs[24:1];
        fg_q    <= fxs[0];
        fs_q    <= |(fx & ~({54{1'b1}} << fr));
        fbase_q <= f_normal ? f_base12[8:0] : 9'd0;
      end
      S_EMIT: begin
        if (emit_fire) begin
          out_data_q.row_number <= row_q[11:0];
          out_data_q.row_value  <= row_bits;
          out_data_q.last_row   <= row_last;
        end
      end
      default: ;
    endcase
  end

endmodule
